[hw/rtl/cau_pkg.sv]
`timescale 1ns / 1ps

package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // Control that travels down the pipeline with each item.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic dz;
    logic sat;
  } ctrl_t;

endpackage

[hw/rtl/cau_if.sv]
`timescale 1ns / 1ps

interface cau_in_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [DATA_WIDTH-1:0] a_re;
  logic signed [DATA_WIDTH-1:0] a_im;
  logic signed [DATA_WIDTH-1:0] b_re;
  logic signed [DATA_WIDTH-1:0] b_im;

  modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r_re;
  logic signed [DATA_WIDTH-1:0] r_im;
  logic [1:0]                   status;

  modport source (output valid, r_re, r_im, status, input ready);
  modport sink   (input valid, r_re, r_im, status, output ready);
endinterface

[hw/rtl/cau_front.sv]
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [1:0]                     in_opcode,
  input  logic signed [DATA_WIDTH-1:0]   in_a_re,
  input  logic signed [DATA_WIDTH-1:0]   in_a_im,
  input  logic signed [DATA_WIDTH-1:0]   in_b_re,
  input  logic signed [DATA_WIDTH-1:0]   in_b_im,
  output ctrl_t                          ctrl_o,
  output logic [DATA_WIDTH-1:0]          res_re_o,
  output logic [DATA_WIDTH-1:0]          res_im_o,
  output logic                           neg_re_o,
  output logic                           neg_im_o,
  output logic [2*DATA_WIDTH-1:0]        mag_re_o,
  output logic [2*DATA_WIDTH-1:0]        mag_im_o,
  output logic [2*DATA_WIDTH-1:0]        den_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  // Returns {saturated, value} for a wide signed value.
  function automatic logic [W:0] clip(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // Stage 1: operand registers.
  ctrl_t                c1_r;
  logic signed [W-1:0]  ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (en) begin
      c1_r <= '{valid: in_valid, op: op_t'(in_opcode), dz: 1'b0, sat: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar1_r <= in_a_re;
      ai1_r <= in_a_im;
      br1_r <= in_b_re;
      bi1_r <= in_b_im;
    end
  end

  // Stage 2: products and the per-part add or subtract.
  ctrl_t                c2_r, c2_nxt;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [W:0]    as_re_r, as_im_r, as_re_nxt, as_im_nxt;

  always_comb begin
    c2_nxt    = c1_r;
    c2_nxt.dz = (br1_r == '0) && (bi1_r == '0);
    if (c1_r.op == OP_SUB) begin
      as_re_nxt = (W+1)'(ar1_r) - (W+1)'(br1_r);
      as_im_nxt = (W+1)'(ai1_r) - (W+1)'(bi1_r);
    end else begin
      as_re_nxt = (W+1)'(ar1_r) + (W+1)'(br1_r);
      as_im_nxt = (W+1)'(ai1_r) + (W+1)'(bi1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
    end else if (en) begin
      c2_r <= c2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r  <= PW'(ar1_r) * PW'(br1_r);
      p_ii_r  <= PW'(ai1_r) * PW'(bi1_r);
      p_ri_r  <= PW'(ar1_r) * PW'(bi1_r);
      p_ir_r  <= PW'(ai1_r) * PW'(br1_r);
      p_bb_r  <= PW'(br1_r) * PW'(br1_r);
      p_cc_r  <= PW'(bi1_r) * PW'(bi1_r);
      as_re_r <= as_re_nxt;
      as_im_r <= as_im_nxt;
    end
  end

  // Stage 3: sums of products, scaling, clamping and the divisor.
  ctrl_t                c3_r, c3_nxt;
  logic signed [SW-1:0] m_re, m_im, d_re, d_im;
  logic [W:0]           cl_re, cl_im;
  logic [W-1:0]         res_re_r, res_im_r;
  logic                 neg_re_r, neg_im_r;
  logic [PW-1:0]        mag_re_r, mag_im_r, den_r;
  logic signed [SW-1:0] abs_re, abs_im;

  always_comb begin
    m_re = SW'(p_rr_r) - SW'(p_ii_r);
    m_im = SW'(p_ri_r) + SW'(p_ir_r);
    d_re = SW'(p_rr_r) + SW'(p_ii_r);
    d_im = SW'(p_ir_r) - SW'(p_ri_r);
    if (c2_r.op == OP_MUL) begin
      cl_re = clip(m_re >>> FRAC_BITS);
      cl_im = clip(m_im >>> FRAC_BITS);
    end else begin
      cl_re = clip(SW'(as_re_r));
      cl_im = clip(SW'(as_im_r));
    end
    abs_re     = d_re[SW-1] ? -d_re : d_re;
    abs_im     = d_im[SW-1] ? -d_im : d_im;
    c3_nxt     = c2_r;
    c3_nxt.sat = (c2_r.op != OP_DIV) && (cl_re[W] || cl_im[W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r <= '0;
    end else if (en) begin
      c3_r <= c3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= cl_re[W-1:0];
      res_im_r <= cl_im[W-1:0];
      neg_re_r <= d_re[SW-1];
      neg_im_r <= d_im[SW-1];
      mag_re_r <= abs_re[PW-1:0];
      mag_im_r <= abs_im[PW-1:0];
      den_r    <= PW'(p_bb_r) + PW'(p_cc_r);
    end
  end

  assign ctrl_o   = c3_r;
  assign res_re_o = res_re_r;
  assign res_im_o = res_im_r;
  assign neg_re_o = neg_re_r;
  assign neg_im_o = neg_im_r;
  assign mag_re_o = mag_re_r;
  assign mag_im_o = mag_im_r;
  assign den_o    = den_r;

endmodule

[hw/rtl/cau_div_step.sv]
`timescale 1ns / 1ps

module cau_div_step import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  ctrl_t                     ctrl_i,
  input  logic [DATA_WIDTH-1:0]     res_re_i,
  input  logic [DATA_WIDTH-1:0]     res_im_i,
  input  logic                      neg_re_i,
  input  logic                      neg_im_i,
  input  logic                      ovf_re_i,
  input  logic                      ovf_im_i,
  input  logic [2*DATA_WIDTH-1:0]   den_i,
  input  logic [2*DATA_WIDTH-1:0]   rem_re_i,
  input  logic [2*DATA_WIDTH-1:0]   rem_im_i,
  input  logic [DATA_WIDTH:0]       low_re_i,
  input  logic [DATA_WIDTH:0]       low_im_i,
  input  logic [DATA_WIDTH:0]       q_re_i,
  input  logic [DATA_WIDTH:0]       q_im_i,
  output ctrl_t                     ctrl_o,
  output logic [DATA_WIDTH-1:0]     res_re_o,
  output logic [DATA_WIDTH-1:0]     res_im_o,
  output logic                      neg_re_o,
  output logic                      neg_im_o,
  output logic                      ovf_re_o,
  output logic                      ovf_im_o,
  output logic [2*DATA_WIDTH-1:0]   den_o,
  output logic [2*DATA_WIDTH-1:0]   rem_re_o,
  output logic [2*DATA_WIDTH-1:0]   rem_im_o,
  output logic [DATA_WIDTH:0]       low_re_o,
  output logic [DATA_WIDTH:0]       low_im_o,
  output logic [DATA_WIDTH:0]       q_re_o,
  output logic [DATA_WIDTH:0]       q_im_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;

  // One restoring step for each part: bring down the next dividend bit.
  logic [PW:0]   sh_re, sh_im;
  logic          ge_re, ge_im;
  logic [PW:0]   df_re, df_im;

  always_comb begin
    sh_re = {rem_re_i, low_re_i[W]};
    sh_im = {rem_im_i, low_im_i[W]};
    ge_re = sh_re >= {1'b0, den_i};
    ge_im = sh_im >= {1'b0, den_i};
    df_re = sh_re - {1'b0, den_i};
    df_im = sh_im - {1'b0, den_i};
  end

  ctrl_t         ctrl_r;
  logic [W-1:0]  res_re_r, res_im_r;
  logic          neg_re_r, neg_im_r, ovf_re_r, ovf_im_r;
  logic [PW-1:0] den_r, rem_re_r, rem_im_r;
  logic [W:0]    low_re_r, low_im_r, q_re_r, q_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (en) begin
      ctrl_r <= ctrl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_i;
      res_im_r <= res_im_i;
      neg_re_r <= neg_re_i;
      neg_im_r <= neg_im_i;
      ovf_re_r <= ovf_re_i;
      ovf_im_r <= ovf_im_i;
      den_r    <= den_i;
      rem_re_r <= ge_re ? df_re[PW-1:0] : sh_re[PW-1:0];
      rem_im_r <= ge_im ? df_im[PW-1:0] : sh_im[PW-1:0];
      low_re_r <= {low_re_i[W-1:0], 1'b0};
      low_im_r <= {low_im_i[W-1:0], 1'b0};
      q_re_r   <= {q_re_i[W-1:0], ge_re};
      q_im_r   <= {q_im_i[W-1:0], ge_im};
    end
  end

  assign ctrl_o   = ctrl_r;
  assign res_re_o = res_re_r;
  assign res_im_o = res_im_r;
  assign neg_re_o = neg_re_r;
  assign neg_im_o = neg_im_r;
  assign ovf_re_o = ovf_re_r;
  assign ovf_im_o = ovf_im_r;
  assign den_o    = den_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign low_re_o = low_re_r;
  assign low_im_o = low_im_r;
  assign q_re_o   = q_re_r;
  assign q_im_o   = q_im_r;

endmodule

[hw/rtl/complex_arithmetic_unit.sv]
`timescale 1ns / 1ps

// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits with FRAC_BITS fraction bits). The unit is a single pipeline
// that takes one item every cycle while the output is not held. Every item,
// whatever the operation, passes the same stages: three front stages form the
// products, sums and divisor, one stage checks quotient overflow, DATA_WIDTH + 1
// restoring divider stages produce one quotient bit each, and the last stage
// clamps and registers the result. The whole pipeline holds while a result
// waits at the output, so nothing is lost or repeated. Status is 0 for a clean
// result, 1 when a part was clamped and 2 for a divide by zero, which returns
// zeros.
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  cau_in_if.sink  in_if,
  cau_out_if.source out_if
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = PW + FRAC_BITS;
  localparam int HW = NW - W - 1;
  localparam int CW = (HW > PW) ? HW : PW;
  localparam int NS = W + 1;
  localparam logic [W:0] MAXPOS = (W+1)'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [W:0] MINMAG = (W+1)'(64'd1 << (W - 1));

  logic  en;
  ctrl_t out_ctrl_r;

  assign en          = !out_ctrl_r.valid || out_if.ready;
  assign in_if.ready = en;

  ctrl_t         f_ctrl;
  logic [W-1:0]  f_res_re, f_res_im;
  logic          f_neg_re, f_neg_im;
  logic [PW-1:0] f_mag_re, f_mag_im, f_den;

  cau_front #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_a_re   (in_if.a_re),
    .in_a_im   (in_if.a_im),
    .in_b_re   (in_if.b_re),
    .in_b_im   (in_if.b_im),
    .ctrl_o    (f_ctrl),
    .res_re_o  (f_res_re),
    .res_im_o  (f_res_im),
    .neg_re_o  (f_neg_re),
    .neg_im_o  (f_neg_im),
    .mag_re_o  (f_mag_re),
    .mag_im_o  (f_mag_im),
    .den_o     (f_den)
  );

  // Divider set-up: the scaled numerator is split into the part above the
  // quotient bits, which must stay below the divisor, and the bits still to
  // be brought down.
  logic [NW-1:0] num_re, num_im;
  logic [HW-1:0] hi_re, hi_im;
  logic          ovf_re_nxt, ovf_im_nxt;

  always_comb begin
    num_re     = NW'(f_mag_re) << FRAC_BITS;
    num_im     = NW'(f_mag_im) << FRAC_BITS;
    hi_re      = num_re[NW-1:W+1];
    hi_im      = num_im[NW-1:W+1];
    ovf_re_nxt = CW'(hi_re) >= CW'(f_den);
    ovf_im_nxt = CW'(hi_im) >= CW'(f_den);
  end

  ctrl_t         s_ctrl   [0:NS];
  logic [W-1:0]  s_res_re [0:NS];
  logic [W-1:0]  s_res_im [0:NS];
  logic          s_neg_re [0:NS];
  logic          s_neg_im [0:NS];
  logic          s_ovf_re [0:NS];
  logic          s_ovf_im [0:NS];
  logic [PW-1:0] s_den    [0:NS];
  logic [PW-1:0] s_rem_re [0:NS];
  logic [PW-1:0] s_rem_im [0:NS];
  logic [W:0]    s_low_re [0:NS];
  logic [W:0]    s_low_im [0:NS];
  logic [W:0]    s_q_re   [0:NS];
  logic [W:0]    s_q_im   [0:NS];

  ctrl_t         p_ctrl_r;
  logic [W-1:0]  p_res_re_r, p_res_im_r;
  logic          p_neg_re_r, p_neg_im_r, p_ovf_re_r, p_ovf_im_r;
  logic [PW-1:0] p_den_r, p_rem_re_r, p_rem_im_r;
  logic [W:0]    p_low_re_r, p_low_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctrl_r <= '0;
    end else if (en) begin
      p_ctrl_r <= f_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_res_re_r <= f_res_re;
      p_res_im_r <= f_res_im;
      p_neg_re_r <= f_neg_re;
      p_neg_im_r <= f_neg_im;
      p_ovf_re_r <= ovf_re_nxt;
      p_ovf_im_r <= ovf_im_nxt;
      p_den_r    <= f_den;
      p_rem_re_r <= ovf_re_nxt ? '0 : PW'(hi_re);
      p_rem_im_r <= ovf_im_nxt ? '0 : PW'(hi_im);
      p_low_re_r <= num_re[W:0];
      p_low_im_r <= num_im[W:0];
    end
  end

  assign s_ctrl[0]   = p_ctrl_r;
  assign s_res_re[0] = p_res_re_r;
  assign s_res_im[0] = p_res_im_r;
  assign s_neg_re[0] = p_neg_re_r;
  assign s_neg_im[0] = p_neg_im_r;
  assign s_ovf_re[0] = p_ovf_re_r;
  assign s_ovf_im[0] = p_ovf_im_r;
  assign s_den[0]    = p_den_r;
  assign s_rem_re[0] = p_rem_re_r;
  assign s_rem_im[0] = p_rem_im_r;
  assign s_low_re[0] = p_low_re_r;
  assign s_low_im[0] = p_low_im_r;
  assign s_q_re[0]   = '0;
  assign s_q_im[0]   = '0;

  for (genvar i = 0; i < NS; i++) begin : g_div
    cau_div_step #(.DATA_WIDTH(W)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctrl_i   (s_ctrl[i]),
      .res_re_i (s_res_re[i]),
      .res_im_i (s_res_im[i]),
      .neg_re_i (s_neg_re[i]),
      .neg_im_i (s_neg_im[i]),
      .ovf_re_i (s_ovf_re[i]),
      .ovf_im_i (s_ovf_im[i]),
      .den_i    (s_den[i]),
      .rem_re_i (s_rem_re[i]),
      .rem_im_i (s_rem_im[i]),
      .low_re_i (s_low_re[i]),
      .low_im_i (s_low_im[i]),
      .q_re_i   (s_q_re[i]),
      .q_im_i   (s_q_im[i]),
      .ctrl_o   (s_ctrl[i+1]),
      .res_re_o (s_res_re[i+1]),
      .res_im_o (s_res_im[i+1]),
      .neg_re_o (s_neg_re[i+1]),
      .neg_im_o (s_neg_im[i+1]),
      .ovf_re_o (s_ovf_re[i+1]),
      .ovf_im_o (s_ovf_im[i+1]),
      .den_o    (s_den[i+1]),
      .rem_re_o (s_rem_re[i+1]),
      .rem_im_o (s_rem_im[i+1]),
      .low_re_o (s_low_re[i+1]),
      .low_im_o (s_low_im[i+1]),
      .q_re_o   (s_q_re[i+1]),
      .q_im_o   (s_q_im[i+1])
    );
  end

  // Final stage: sign and clamp the quotients, pick the result.
  ctrl_t        l_ctrl;
  logic [W:0]   q_re, q_im, nq_re, nq_im;
  logic         dsat_re, dsat_im;
  logic [W-1:0] dv_re, dv_im;
  logic [W-1:0] r_re_nxt, r_im_nxt;
  status_t      st_nxt;
  logic [W-1:0] r_re_r, r_im_r;
  status_t      st_r;

  always_comb begin
    l_ctrl = s_ctrl[NS];
    q_re   = s_q_re[NS];
    q_im   = s_q_im[NS];
    nq_re  = -q_re;
    nq_im  = -q_im;
    if (s_neg_re[NS]) begin
      dsat_re = s_ovf_re[NS] || (q_re > MINMAG);
      dv_re   = dsat_re ? MINMAG[W-1:0] : nq_re[W-1:0];
    end else begin
      dsat_re = s_ovf_re[NS] || (q_re > MAXPOS);
      dv_re   = dsat_re ? MAXPOS[W-1:0] : q_re[W-1:0];
    end
    if (s_neg_im[NS]) begin
      dsat_im = s_ovf_im[NS] || (q_im > MINMAG);
      dv_im   = dsat_im ? MINMAG[W-1:0] : nq_im[W-1:0];
    end else begin
      dsat_im = s_ovf_im[NS] || (q_im > MAXPOS);
      dv_im   = dsat_im ? MAXPOS[W-1:0] : q_im[W-1:0];
    end

    if (l_ctrl.op == OP_DIV) begin
      if (l_ctrl.dz) begin
        r_re_nxt = '0;
        r_im_nxt = '0;
        st_nxt   = ST_DZ;
      end else begin
        r_re_nxt = dv_re;
        r_im_nxt = dv_im;
        st_nxt   = (dsat_re || dsat_im) ? ST_SAT : ST_OK;
      end
    end else begin
      r_re_nxt = s_res_re[NS];
      r_im_nxt = s_res_im[NS];
      st_nxt   = l_ctrl.sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctrl_r <= '0;
    end else if (en) begin
      out_ctrl_r <= l_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_re_r <= r_re_nxt;
      r_im_r <= r_im_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_if.valid  = out_ctrl_r.valid;
  assign out_if.r_re   = r_re_r;
  assign out_if.r_im   = r_im_r;
  assign out_if.status = st_r;

endmodule

[sim/complex_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int LATENCY = DW + 6;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    op_t            op;
    logic [DW-1:0]  a_re;
    logic [DW-1:0]  a_im;
    logic [DW-1:0]  b_re;
    logic [DW-1:0]  b_im;
  } cmd_t;

  typedef struct packed {
    logic [DW-1:0] r_re;
    logic [DW-1:0] r_im;
    status_t       status;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  cau_out_if #(.DATA_WIDTH(DW)) out_ch ();

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   error_count = 0;
  int   results_seen = 0;
  int   idle_pct = 21;
  int   stall_pct = 21;
  int   op_count[4];
  int   sat_count = 0;
  int   dz_count = 0;
  int   quiet_cycles = 0;

  // Clamp a wide signed value to the data range, noting saturation.
  function automatic logic [DW-1:0] clamp_part(input longint v, inout bit sat);
    longint hi, lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -(longint'(1) <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Exact quotient truncated toward zero; magnitudes fit comfortably in 64 bits.
  function automatic longint scaled_quot(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic res_t complex_result(input cmd_t c);
    res_t r;
    bit sat;
    longint ar, ai, br, bi, den, pr, pi;
    ar = longint'($signed(c.a_re));
    ai = longint'($signed(c.a_im));
    br = longint'($signed(c.b_re));
    bi = longint'($signed(c.b_im));
    sat = 1'b0;
    r.status = ST_OK;
    r.r_re = '0;
    r.r_im = '0;
    case (c.op)
      OP_ADD: begin
        r.r_re = clamp_part(ar + br, sat);
        r.r_im = clamp_part(ai + bi, sat);
      end
      OP_SUB: begin
        r.r_re = clamp_part(ar - br, sat);
        r.r_im = clamp_part(ai - bi, sat);
      end
      OP_MUL: begin
        pr = ar * br - ai * bi;
        pi = ar * bi + ai * br;
        r.r_re = clamp_part(pr >>> FB, sat);
        r.r_im = clamp_part(pi >>> FB, sat);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DZ;
        end else begin
          r.r_re = clamp_part(scaled_quot(ar * br + ai * bi, den), sat);
          r.r_im = clamp_part(scaled_quot(ai * br - ar * bi, den), sat);
        end
      end
    endcase
    if (r.status == ST_OK && sat) r.status = ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
             want);
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        cmd_t acc;
        acc = cmd_t'({in_ch.opcode, in_ch.a_re, in_ch.a_im, in_ch.b_re, in_ch.b_im});
        expected_results.push_back(complex_result(acc));
        op_count[acc.op]++;
      end
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= c.op;
        in_ch.a_re   <= c.a_re;
        in_ch.a_im   <= c.a_im;
        in_ch.b_re   <= c.b_re;
        in_ch.b_im   <= c.b_im;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, r_re", $signed(out_ch.r_re), 0);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_ch.r_re !== e.r_re)
            report_mismatch("r_re", $signed(out_ch.r_re), $signed(e.r_re));
          if (out_ch.r_im !== e.r_im)
            report_mismatch("r_im", $signed(out_ch.r_im), $signed(e.r_im));
          if (out_ch.status !== e.status)
            report_mismatch("status", out_ch.status, e.status);
          if (e.status == ST_SAT) sat_count++;
          if (e.status == ST_DZ) dz_count++;
        end
        results_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("complex_arithmetic_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(512)) - 256);
      3: return 16'($signed($urandom_range(8192)) - 4096);
      4: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_cmd(input op_t op, input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                         input logic [DW-1:0] br, input logic [DW-1:0] bi);
    cmd_t c;
    c.op = op;
    c.a_re = ar;
    c.a_im = ai;
    c.b_re = br;
    c.b_im = bi;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.a_re = '0;
    in_ch.a_im = '0;
    in_ch.b_re = '0;
    in_ch.b_im = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every operation, saturation and a zero divisor.
    add_cmd(OP_ADD, 16'h0100, 16'h0200, 16'h0080, 16'hff00);
    add_cmd(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    add_cmd(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    add_cmd(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    add_cmd(OP_SUB, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    add_cmd(OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    add_cmd(OP_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    add_cmd(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_cmd(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    add_cmd(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    add_cmd(OP_MUL, 16'h0001, 16'h0000, 16'hffff, 16'h0000);
    add_cmd(OP_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    add_cmd(OP_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
    add_cmd(OP_DIV, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    add_cmd(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    add_cmd(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0001);
    add_cmd(OP_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000);
    add_cmd(OP_DIV, 16'hff00, 16'h0001, 16'h0300, 16'hfd00);
    add_cmd(OP_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000);
    add_cmd(OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    wait_drained();

    // Random with idling, then a stretch with none, then random again.
    for (int i = 0; i < 1600; i++) begin
      if (i == 600) begin
        wait_drained();
        idle_pct = 0;
        stall_pct = 0;
      end
      if (i == 900) begin
        wait_drained();
        idle_pct = 21;
        stall_pct = 21;
      end
      add_cmd(op_t'($urandom_range(3)), rand_part(), rand_part(), rand_part(), rand_part());
    end
    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);

    $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d", results_seen,
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("saturated results %0d, divide-by-zero results %0d", sat_count, dz_count);
    if (error_count == 0 && expected_results.size() == 0)
      $display("complex_arithmetic_unit_tb: PASS");
    else
      $display("complex_arithmetic_unit_tb: FAIL");
    $finish;
  end

endmodule

[files.f]
hw/rtl/cau_pkg.sv
hw/rtl/cau_if.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_step.sv
hw/rtl/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_tb.sv
